[rtl/core/rfid_uart_frame_checker_core_macros.svh]
// Assertion helpers for the RTL of the frame checker, included by rufc_engine.sv.
`ifndef RFID_UART_FRAME_CHECKER_CORE_MACROS_SVH
`define RFID_UART_FRAME_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RUFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RUFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

[rtl/core/rufc_pkg.sv]
`default_nettype none
package rufc_pkg;

  localparam int TOKEN_CHARS = 12;
  localparam int CHAR_W      = 8;
  localparam int HALF_CHARS  = TOKEN_CHARS / 2;
  localparam int HALF_W      = HALF_CHARS * CHAR_W;
  localparam int COUNT_W     = 4;
  localparam int ELAPSED_W   = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int CHECK_W     = 13;

  localparam logic [CHAR_W-1:0]    BYTE_START = 8'd2;
  localparam logic [CHAR_W-1:0]    BYTE_END   = 8'd3;
  localparam logic [CHAR_W-1:0]    DIGIT_LO   = 8'd48;
  localparam logic [CHAR_W-1:0]    DIGIT_HI   = 8'd57;
  localparam logic [CHECK_W-1:0]   DIGIT_BASE = 13'd48;
  localparam logic [CHECK_W-1:0]   ALPHA_BASE = 13'd55;
  localparam logic [COUNT_W-1:0]   COUNT_FULL = 4'd12;
  localparam logic [COUNT_W-1:0]   COUNT_OVER = 4'd13;

  localparam logic [CFG_DATA_W-1:0] ATTEMPT_LIMIT_RST = 8'd3;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_MS_RST    = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 2'd1;

  typedef enum logic [1:0] {
    STATUS_TOKEN     = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_TIMEOUT   = 2'd2
  } status_t;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  valid;
    logic  mode;
    char_t rx_byte;
  } item_t;

endpackage
`default_nettype wire

[rtl/core/rufc_ifs.sv]
`default_nettype none
interface rufc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface rufc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] token_first_half;
  logic [47:0] token_second_half;

  modport source (output valid, output status, output token_first_half,
                  output token_second_half, input ready);
  modport sink (input valid, input status, input token_first_half,
                input token_second_half, output ready);
endinterface
`default_nettype wire

[rtl/core/rfid_uart_frame_checker_core.sv]
// Frame checker for a 125 kHz RFID reader that sends its tokens over a UART.
// The input channel carries one beat per received byte (mode 0) or per
// one-millisecond tick (mode 1). The result channel carries a beat only when
// a session ends: a good token with both halves of its characters, a failure
// after too many bad frames, or a timeout when no start byte came in time.
// The configuration port writes the attempt limit (index 0) and the timeout in
// milliseconds (index 1); the user writes them only while the block is idle, which the block itself does not enforce.
// An accepted beat is held in the input register until the frame logic takes
// it, is evaluated there and any result is written into the output register.
// The block takes one input beat every cycle while the output register is
// empty or being drained; the frame state is updated by a single pass of
// logic between the input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more beat; input ready then drops until
// the result is taken. Beats that produce no result never wait on the
// receiver once the output register is empty or being drained.
// Reset restores the register defaults (3 attempts, 100 ms), closes any
// frame and clears the counters; it takes effect at the next clock edge.
`default_nettype none
module rfid_uart_frame_checker_core
  import rufc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rufc_in_if.sink                    in_ch,
  rufc_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t item;
  logic  take;

  rufc_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  rufc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (take),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/rufc_in_stage.sv]
`default_nettype none
module rufc_in_stage
  import rufc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  rufc_in_if.sink   in_ch,
  input  wire logic take,
  output item_t     item
);

  logic  valid_r, valid_nxt;
  logic  mode_r;
  char_t byte_r;
  logic  load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= in_ch.mode;
      byte_r <= in_ch.rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.mode    = mode_r;
  assign item.rx_byte = byte_r;

endmodule
`default_nettype wire

[rtl/core/rufc_checksum.sv]
`default_nettype none
module rufc_checksum
  import rufc_pkg::*;
(
  input  wire char_t chars [TOKEN_CHARS],
  output logic       ok
);

  localparam int PAIRS = TOKEN_CHARS / 2;

  logic [CHECK_W-1:0] dec   [TOKEN_CHARS];
  logic [CHECK_W-1:0] pair  [PAIRS];
  logic [CHECK_W-1:0] x;

  always_comb begin
    for (int i = 0; i < TOKEN_CHARS; i++) begin
      if (chars[i] >= DIGIT_LO && chars[i] <= DIGIT_HI) begin
        dec[i] = {{(CHECK_W-CHAR_W){1'b0}}, chars[i]} - DIGIT_BASE;
      end else begin
        dec[i] = {{(CHECK_W-CHAR_W){1'b0}}, chars[i]} - ALPHA_BASE;
      end
    end
    for (int p = 0; p < PAIRS; p++) begin
      pair[p] = {dec[2*p][CHECK_W-5:0], 4'b0000} + dec[2*p+1];
    end
    x = '0;
    for (int p = 0; p < PAIRS - 1; p++) begin
      x = x ^ pair[p];
    end
    ok = (x == pair[PAIRS-1]);
  end

endmodule
`default_nettype wire

[rtl/core/rufc_engine.sv]
`default_nettype none
`include "rfid_uart_frame_checker_core_macros.svh"
module rufc_engine
  import rufc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire item_t                 item,
  output logic                       take,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  rufc_out_if.source                 out_ch
);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [7:0]           ATTEMPT_MAX = '1;

  logic [CFG_DATA_W-1:0] attempt_limit_r;
  logic [CFG_DATA_W-1:0] timeout_ms_r;

  logic                 frame_open_r, frame_open_nxt;
  logic [COUNT_W-1:0]   char_count_r, char_count_nxt;
  logic [7:0]           attempt_count_r, attempt_count_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  char_t                store_r [TOKEN_CHARS];

  logic                 out_valid_r;
  status_t              status_r;
  logic [HALF_W-1:0]    first_r;
  logic [HALF_W-1:0]    second_r;

  logic    proc;
  logic    emit;
  status_t emit_status;
  logic    store_we;
  logic    check_ok;
  logic    good;
  logic    restart;

  rufc_checksum u_checksum (
    .chars (store_r),
    .ok    (check_ok)
  );

  assign take = item.valid && (!out_valid_r || out_ch.ready);
  assign proc = take;
  assign good = frame_open_r && (char_count_r == COUNT_FULL) && check_ok;

  always_comb begin
    frame_open_nxt    = frame_open_r;
    char_count_nxt    = char_count_r;
    attempt_count_nxt = attempt_count_r;
    elapsed_nxt       = elapsed_r;
    emit              = 1'b0;
    emit_status       = STATUS_TOKEN;
    store_we          = 1'b0;
    restart           = 1'b0;
    elapsed_inc       = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    if (proc) begin
      if (item.mode) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {1'b0, timeout_ms_r}) begin
          emit        = 1'b1;
          emit_status = STATUS_TIMEOUT;
          restart     = 1'b1;
        end
      end else if (item.rx_byte == BYTE_START) begin
        if (attempt_count_r != ATTEMPT_MAX) begin
          attempt_count_nxt = attempt_count_r + 1'b1;
        end
        elapsed_nxt    = '0;
        char_count_nxt = '0;
        frame_open_nxt = 1'b1;
      end else if (item.rx_byte == BYTE_END) begin
        frame_open_nxt = 1'b0;
        if (good) begin
          emit        = 1'b1;
          emit_status = STATUS_TOKEN;
          restart     = 1'b1;
        end else if (attempt_count_r > attempt_limit_r) begin
          emit        = 1'b1;
          emit_status = STATUS_EXHAUSTED;
          restart     = 1'b1;
        end
      end else if (frame_open_r) begin
        store_we = (char_count_r < COUNT_FULL);
        if (char_count_r < COUNT_OVER) begin
          char_count_nxt = char_count_r + 1'b1;
        end
      end
      if (restart) begin
        frame_open_nxt    = 1'b0;
        char_count_nxt    = '0;
        attempt_count_nxt = '0;
        elapsed_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_limit_r <= ATTEMPT_LIMIT_RST;
      timeout_ms_r    <= TIMEOUT_MS_RST;
      frame_open_r    <= 1'b0;
      char_count_r    <= '0;
      attempt_count_r <= '0;
      elapsed_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTEMPT_LIMIT: attempt_limit_r <= cfg_wdata;
          CFG_TIMEOUT_MS:    timeout_ms_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
      frame_open_r    <= frame_open_nxt;
      char_count_r    <= char_count_nxt;
      attempt_count_r <= attempt_count_nxt;
      elapsed_r       <= elapsed_nxt;
      if (proc) begin
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[char_count_r] <= item.rx_byte;
    end
    if (proc && emit) begin
      status_r <= emit_status;
      if (emit_status == STATUS_TOKEN) begin
        first_r  <= {store_r[0], store_r[1], store_r[2],
                     store_r[3], store_r[4], store_r[5]};
        second_r <= {store_r[6], store_r[7], store_r[8],
                     store_r[9], store_r[10], store_r[11]};
      end else begin
        first_r  <= '0;
        second_r <= '0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = status_r;
  assign out_ch.token_first_half  = first_r;
  assign out_ch.token_second_half = second_r;

  `RUFC_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, char_count_r <= COUNT_OVER)
  `RUFC_ASSERT_NEXT(a_start_clears_time, clk, rst_n,
                    proc && !item.mode && item.rx_byte == BYTE_START, elapsed_r == '0)
  `RUFC_ASSERT_NEXT(a_result_restarts, clk, rst_n, proc && emit,
                    attempt_count_r == '0 && !frame_open_r && out_valid_r)
  `RUFC_ASSERT_SAME(a_fail_zero_token, clk, rst_n,
                    out_valid_r && status_r != STATUS_TOKEN,
                    first_r == '0 && second_r == '0)

endmodule
`default_nettype wire
